// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared types, pipeline stage numbers, sector codes and hue constants.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int NUM_STAGES = 8;

    localparam int STG_WRAP  = 0;
    localparam int STG_FOLD  = 1;
    localparam int STG_SPLIT = 2;
    localparam int STG_TERM  = 3;
    localparam int STG_MUL   = 4;
    localparam int STG_SCALE = 5;
    localparam int STG_DIV   = 6;
    localparam int STG_OUT   = 7;

    typedef logic [2:0] t_sector;

    localparam t_sector SEC_R2Y = 3'd0;
    localparam t_sector SEC_Y2G = 3'd1;
    localparam t_sector SEC_G2C = 3'd2;
    localparam t_sector SEC_C2B = 3'd3;
    localparam t_sector SEC_B2M = 3'd4;
    localparam t_sector SEC_M2R = 3'd5;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

    localparam logic [16:0] HUE_BIAS   = 17'd33120;
    localparam logic [15:0] HUE_RECIP  = 16'd46603;
    localparam logic [8:0]  DEG_FULL   = 9'd360;
    localparam logic [8:0]  DEG_SECTOR = 9'd60;
    localparam logic [12:0] DIV15_RECIP = 13'd4370;

    function automatic int sample_width(input int frac_bits);
        int w;
        w = (frac_bits >= 11) ? 11 : frac_bits + 1;
        return w;
    endfunction

endpackage

// ----- rtl/hsv2rgb_ifs.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB channel interfaces
// Valid/ready channels for the HSV input items and the RGB result items.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] hue_degrees;
    logic signed [11:0] saturation;
    logic signed [11:0] brightness;

    modport source (output valid, hue_degrees, saturation, brightness, input ready);
    modport sink (input valid, hue_degrees, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

// ----- rtl/hsv2rgb_hue.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB hue stages
// Wraps the hue into 0..359 and splits it into a sector and a remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_hue (
    input  logic                     i_clk,
    input  hsv2rgb_pkg::t_pipe_ctl   i_ctl,
    input  logic [15:0]              i_hue,
    output hsv2rgb_pkg::t_sector     o_sector,
    output logic [5:0]               o_rem
);
    import hsv2rgb_pkg::*;

    logic [16:0] hue_u;
    logic [32:0] wrap_prod;
    logic [16:0] r_u;
    logic [7:0]  r_qe;
    logic [16:0] fold_d;
    logic [9:0]  fold_lo;
    logic [8:0]  r_h;
    logic [8:0]  n_h;
    t_sector     r_sector;
    t_sector     n_sector;
    logic [5:0]  r_rem;
    logic [5:0]  n_rem;

    // The bias is a multiple of 360 that makes every hue positive.
    assign hue_u     = {i_hue[15], i_hue} + HUE_BIAS;
    assign wrap_prod = 33'(hue_u) * 33'(HUE_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_WRAP]) begin
            r_u  <= hue_u;
            r_qe <= wrap_prod[31:24];
        end
    end

    // The quotient estimate is exact or one short, so one correction suffices.
    assign fold_d  = r_u - 17'(r_qe) * 17'(DEG_FULL);
    assign fold_lo = fold_d[9:0];

    always_comb begin
        if (fold_lo >= 10'(DEG_FULL)) begin
            n_h = 9'(fold_lo - 10'(DEG_FULL));
        end else begin
            n_h = 9'(fold_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_FOLD]) begin
            r_h <= n_h;
        end
    end

    always_comb begin
        priority if (r_h < DEG_SECTOR) begin
            n_sector = SEC_R2Y;
            n_rem    = 6'(r_h);
        end else if (r_h < 9'(DEG_SECTOR * 2)) begin
            n_sector = SEC_Y2G;
            n_rem    = 6'(r_h - DEG_SECTOR);
        end else if (r_h < 9'(DEG_SECTOR * 3)) begin
            n_sector = SEC_G2C;
            n_rem    = 6'(r_h - 9'(DEG_SECTOR * 2));
        end else if (r_h < 9'(DEG_SECTOR * 4)) begin
            n_sector = SEC_C2B;
            n_rem    = 6'(r_h - 9'(DEG_SECTOR * 3));
        end else if (r_h < 9'(DEG_SECTOR * 5)) begin
            n_sector = SEC_B2M;
            n_rem    = 6'(r_h - 9'(DEG_SECTOR * 4));
        end else begin
            n_sector = SEC_M2R;
            n_rem    = 6'(r_h - 9'(DEG_SECTOR * 5));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_SPLIT]) begin
            r_sector <= n_sector;
            r_rem    <= n_rem;
        end
    end

    assign o_sector = r_sector;
    assign o_rem    = r_rem;

endmodule

// ----- rtl/hsv2rgb_scale.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB channel scaler
// Forms floor(255 * v * t / (60 * ONE^2)) over three register stages.
// ----------------------------------------------------------------------------
module hsv2rgb_scale #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                                             i_clk,
    input  hsv2rgb_pkg::t_pipe_ctl                           i_ctl,
    input  logic [hsv2rgb_pkg::sample_width(FRACTION_BITS)-1:0] i_v,
    input  logic [FRACTION_BITS+5:0]                         i_t,
    output logic [7:0]                                       o_chan
);
    import hsv2rgb_pkg::*;

    localparam int SW  = sample_width(FRACTION_BITS);
    localparam int TW  = FRACTION_BITS + 6;
    localparam int PW  = SW + TW;
    localparam int SH  = 2 * FRACTION_BITS + 2;
    localparam int SCW = (PW + 8 > SH + 12) ? PW + 8 : SH + 12;

    logic [PW-1:0]  r_prod;
    logic [SCW-1:0] prod_ext;
    logic [SCW-1:0] scaled;
    logic [11:0]    r_y;
    logic [24:0]    div_prod;
    logic [7:0]     r_chan;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_MUL]) begin
            r_prod <= PW'(i_v) * PW'(i_t);
        end
    end

    // Dropping 2F+2 bits leaves a value below 15 * 256 that is then divided by 15.
    assign prod_ext = {{(SCW-PW){1'b0}}, r_prod};
    assign scaled   = (prod_ext << 8) - prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_SCALE]) begin
            r_y <= scaled[SH +: 12];
        end
    end

    assign div_prod = 25'(r_y) * 25'(DIV15_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_DIV]) begin
            r_chan <= div_prod[23:16];
        end
    end

    assign o_chan = r_chan;

endmodule

// ----- rtl/hsv2rgb_to_rgb_converter.sv -----
// An item passes through eight register stages, the first of which is loaded at the
// edge that accepts it.
// Throughput: one item per cycle unless stalled; a stage holds its item while the next is full.
// The per-stage ready chain lets items close up behind a stalled output.
// Reset clears the stage valid bits only; no result is shown until an item arrives.
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Wraps hue, clamps saturation and value, and forms exact truncated RGB bytes.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hsv2rgb_in_if.sink           i_hsv,
    hsv2rgb_out_if.source        o_rgb
);
    import hsv2rgb_pkg::*;

    localparam int SW = sample_width(FRACTION_BITS);
    localparam int TW = FRACTION_BITS + 6;
    localparam logic [31:0]   ONE_L  = 32'd1 << FRACTION_BITS;
    localparam logic [TW-1:0] FULL_T = TW'(60) << FRACTION_BITS;

    t_pipe_ctl             ctl;
    logic [NUM_STAGES-1:0] r_vld;

    logic signed [31:0] sat_ext;
    logic signed [31:0] val_ext;
    logic [SW-1:0]      n_s;
    logic [SW-1:0]      n_v;
    logic [SW-1:0]      r_s [STG_WRAP:STG_SPLIT];
    logic [SW-1:0]      r_v [STG_WRAP:STG_TERM];

    t_sector            hue_sector;
    logic [5:0]         hue_rem;
    t_sector            r_sec [STG_TERM:STG_DIV];

    logic [SW+5:0]      s_r;
    logic [SW+5:0]      s_nr;
    logic [SW+5:0]      s_60;
    logic [TW-1:0]      r_tp;
    logic [TW-1:0]      r_tq;
    logic [TW-1:0]      r_tt;

    logic [7:0]         ch_v;
    logic [7:0]         ch_p;
    logic [7:0]         ch_q;
    logic [7:0]         ch_t;
    logic [7:0]         r_red;
    logic [7:0]         r_green;
    logic [7:0]         r_blue;
    logic [7:0]         n_red;
    logic [7:0]         n_green;
    logic [7:0]         n_blue;

    always_comb begin
        ctl.load[STG_OUT] = !r_vld[STG_OUT] || o_rgb.ready;
        for (int k = STG_OUT - 1; k >= 0; k--) begin
            ctl.load[k] = !r_vld[k] || ctl.load[k+1];
        end
    end

    assign i_hsv.ready = ctl.load[STG_WRAP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ctl.load[STG_WRAP]) begin
                r_vld[STG_WRAP] <= i_hsv.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ctl.load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign sat_ext = {{20{i_hsv.saturation[11]}}, i_hsv.saturation};
    assign val_ext = {{20{i_hsv.brightness[11]}}, i_hsv.brightness};

    always_comb begin
        priority if (sat_ext < 0) begin
            n_s = '0;
        end else if (sat_ext > $signed(ONE_L)) begin
            n_s = SW'(ONE_L);
        end else begin
            n_s = SW'(sat_ext);
        end
        priority if (val_ext < 0) begin
            n_v = '0;
        end else if (val_ext > $signed(ONE_L)) begin
            n_v = SW'(ONE_L);
        end else begin
            n_v = SW'(val_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[STG_WRAP]) begin
            r_s[STG_WRAP] <= n_s;
            r_v[STG_WRAP] <= n_v;
        end
        for (int k = STG_FOLD; k <= STG_SPLIT; k++) begin
            if (ctl.load[k]) begin
                r_s[k] <= r_s[k-1];
            end
        end
        for (int k = STG_FOLD; k <= STG_TERM; k++) begin
            if (ctl.load[k]) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    hsv2rgb_hue u_hue (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_hue    (i_hsv.hue_degrees),
        .o_sector (hue_sector),
        .o_rem    (hue_rem)
    );

    assign s_r  = (SW+6)'(r_s[STG_SPLIT]) * (SW+6)'(hue_rem);
    assign s_nr = (SW+6)'(r_s[STG_SPLIT]) * (SW+6)'(6'd60 - hue_rem);
    assign s_60 = (SW+6)'(r_s[STG_SPLIT]) * (SW+6)'(60);

    always_ff @(posedge i_clk) begin
        if (ctl.load[STG_TERM]) begin
            r_tp           <= FULL_T - TW'(s_60);
            r_tq           <= FULL_T - TW'(s_r);
            r_tt           <= FULL_T - TW'(s_nr);
            r_sec[STG_TERM] <= hue_sector;
        end
        for (int k = STG_MUL; k <= STG_DIV; k++) begin
            if (ctl.load[k]) begin
                r_sec[k] <= r_sec[k-1];
            end
        end
    end

    hsv2rgb_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale_v (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_v    (r_v[STG_TERM]),
        .i_t    (FULL_T),
        .o_chan (ch_v)
    );

    hsv2rgb_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale_p (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_v    (r_v[STG_TERM]),
        .i_t    (r_tp),
        .o_chan (ch_p)
    );

    hsv2rgb_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale_q (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_v    (r_v[STG_TERM]),
        .i_t    (r_tq),
        .o_chan (ch_q)
    );

    hsv2rgb_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale_t (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_v    (r_v[STG_TERM]),
        .i_t    (r_tt),
        .o_chan (ch_t)
    );

    always_comb begin
        unique case (r_sec[STG_DIV])
            SEC_Y2G: begin
                n_red = ch_q; n_green = ch_v; n_blue = ch_p;
            end
            SEC_G2C: begin
                n_red = ch_p; n_green = ch_v; n_blue = ch_t;
            end
            SEC_C2B: begin
                n_red = ch_p; n_green = ch_q; n_blue = ch_v;
            end
            SEC_B2M: begin
                n_red = ch_t; n_green = ch_p; n_blue = ch_v;
            end
            SEC_M2R: begin
                n_red = ch_v; n_green = ch_p; n_blue = ch_q;
            end
            default: begin
                n_red = ch_v; n_green = ch_t; n_blue = ch_p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[STG_OUT]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_rgb.valid = r_vld[STG_OUT];
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

`ifndef SYNTH
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[STG_OUT] |-> i_hsv.ready)
        else $error("input not ready although the output stage is empty");

    a_term_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STG_TERM] && !ctl.load[STG_TERM] |=>
            r_vld[STG_TERM] && $stable(r_tp) && $stable(r_tq) && $stable(r_tt))
        else $error("term stage lost or changed a stalled item");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rgb.valid)
        else $error("result shown straight after reset");
`endif

endmodule
